FILE: hdl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program stream demux package
// Parse phases, event codes, the result record and the fixed numbers of the stream syntax.
// ----------------------------------------------------------------------------
package psd_pkg;

    typedef enum logic [3:0] {
        PH_HUNT        = 4'd0,
        PH_PACK        = 4'd1,
        PH_PACK2_LEN   = 4'd2,
        PH_PACK2_STUFF = 4'd3,
        PH_PES_START   = 4'd4,
        PH_PES2_LEN    = 4'd5,
        PH_PES2_BODY   = 4'd6,
        PH_PES1_STUFF  = 4'd7,
        PH_PES1_STD    = 4'd8,
        PH_PES1_PTS    = 4'd9,
        PH_PES1_PTSDTS = 4'd10,
        PH_SKIPLEN     = 4'd11,
        PH_BODY        = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_PTS       = 3'd1,
        EV_PROG_END  = 3'd2,
        EV_BAD_PACK  = 3'd3,
        EV_STUFF_OVF = 3'd4,
        EV_NOT_SYS   = 3'd5
    } event_t;

    localparam logic [7:0] ID_END  = 8'hB9;
    localparam logic [7:0] ID_PACK = 8'hBA;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  payload_byte;
        logic [31:0] time_stamp;
    } result_t;

endpackage

FILE: hdl/psd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one program stream byte.
// ----------------------------------------------------------------------------
interface psd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

FILE: hdl/psd_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output event channel
// Valid/ready channel carrying one demux event.
// ----------------------------------------------------------------------------
interface psd_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [31:0] time_stamp;
    modport source (output valid, output event_kind, output payload_byte,
                    output time_stamp, input ready);
    modport sink (input valid, input event_kind, input payload_byte,
                  input time_stamp, output ready);
endinterface

FILE: hdl/program_stream_demux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program stream demux top level
// The result of an input transfer is registered and shown in the cycle after it.
// Throughput: one byte per cycle while no stalled result holds the input off.
// A stalled output holds one result; input ready follows output space.
// Reset (rst_n low, asynchronous) returns to start code hunting and sets
// stream_select to 0xE0; the captured header bytes have no reset.
// ----------------------------------------------------------------------------
module program_stream_demux
    import psd_pkg::*;
#(
    parameter int HEADER_STORE   = 32,
    parameter int STUFFING_LIMIT = 23
) (
    input  logic        clk,
    input  logic        rst_n,
    psd_byte_if.sink    in_ch,
    psd_event_if.source out_ch,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data
);
    logic [7:0] sel_reg;
    logic       step;
    logic       res_valid;
    result_t    res;
    logic       out_valid_reg;
    result_t    out_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;

    psd_parser #(
        .HEADER_STORE(HEADER_STORE),
        .STUFFING_LIMIT(STUFFING_LIMIT)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .data_byte(in_ch.data_byte),
        .stream_select(sel_reg),
        .res_valid(res_valid),
        .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 8'hE0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                sel_reg <= cfg_data;
            if (in_ch.ready)
                out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && res_valid)
            out_reg <= res;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.event_kind = out_reg.event_kind;
    assign out_ch.payload_byte = out_reg.payload_byte;
    assign out_ch.time_stamp = out_reg.time_stamp;

    // A held result must not change while it waits for a transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result changed while stalled");
    // Input is refused only while a result is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_valid_reg && !out_ch.ready)
        else $error("input stalled without cause");
    // A result shows up only after an input transfer.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result without input");
endmodule

FILE: hdl/psd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program stream parser
// Per-byte parse step: start code hunt, pack and PES header parsing and
// payload counting. Holds the captured header bytes and all parse state.
// ----------------------------------------------------------------------------
module psd_parser
    import psd_pkg::*;
#(
    parameter int HEADER_STORE   = 32,
    parameter int STUFFING_LIMIT = 23
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic [7:0] stream_select,
    output logic       res_valid,
    output result_t    res
);
    phase_t      phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [8:0]  count_reg, count_next;
    logic [8:0]  target_reg, target_next;
    logic [16:0] remain_reg, remain_next;
    logic        pass_reg, pass_next;

    // Fixed header bytes are kept in dedicated registers so that several
    // can be read together.
    logic [7:0] h4_reg, h5_reg, h6_reg, h7_reg, h8_reg;
    logic [7:0] h9_reg, h10_reg, h11_reg, h12_reg, h13_reg;
    logic [7:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic [7:0] p5_reg, p6_reg, p7_reg, p8_reg;

    logic       keep_byte_en;
    logic [7:0] keep_byte;
    logic       wr_en;
    logic       ev_valid;
    event_t     ev_kind;
    logic [7:0] ev_pay;
    logic [31:0] ev_pts;

    function automatic logic [7:0] hsel(input logic [8:0] i, input logic [7:0] cur,
                                        input logic [8:0] cnt_old,
                                        input logic [7:0] reg_val);
        // The byte at index i is either this byte or an already stored one.
        if (i == cnt_old)
            return cur;
        return reg_val;
    endfunction

    function automatic logic [31:0] pts_of(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [7:0] b4);
        logic [31:0] v;
        v = ({25'd0, b0[7:1]} << 30) | ({24'd0, b1} << 22) |
            ({25'd0, b2[7:1]} << 15) | ({24'd0, b3} << 7) | {25'd0, b4[7:1]};
        return v;
    endfunction

    // Header bytes past the store length read as zero.
    assign keep_byte_en = (count_reg < 9'(HEADER_STORE));
    assign keep_byte = keep_byte_en ? data_byte : 8'd0;

    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  h4, h5, h6, h7, h8, h13;
        logic [16:0] total;
        logic [8:0]  tgt;
        logic [3:0]  nib;
        logic        pts_ok;
        b = data_byte;
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        target_next = target_reg;
        remain_next = remain_reg;
        pass_next   = pass_reg;
        wr_en       = 1'b0;
        ev_valid    = 1'b0;
        ev_kind     = EV_PAYLOAD;
        ev_pay      = 8'd0;
        ev_pts      = 32'd0;
        h4  = hsel(9'd4, b, count_reg, h4_reg);
        h5  = hsel(9'd5, b, count_reg, h5_reg);
        h6  = hsel(9'd6, b, count_reg, h6_reg);
        h7  = hsel(9'd7, b, count_reg, h7_reg);
        h8  = hsel(9'd8, b, count_reg, h8_reg);
        h13 = hsel(9'd13, b, count_reg, h13_reg);
        tgt = target_reg;
        nib = b[7:4];
        pts_ok = 1'b0;
        total = 17'd6 + {1'b0, h4, h5};

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (window_reg == 24'h000001)
                begin
                    count_next = 9'd4;
                    if (b == ID_END)
                    begin
                        window_next = 24'hFFFFFF;
                        count_next = 9'd0;
                        target_next = 9'd0;
                        ev_valid = 1'b1;
                        ev_kind = EV_PROG_END;
                    end
                    else if (b == ID_PACK)
                    begin
                        phase_next = PH_PACK;
                        target_next = 9'd12;
                    end
                    else if (b == stream_select)
                    begin
                        phase_next = PH_PES_START;
                        target_next = 9'd7;
                    end
                    else if (b < ID_END)
                    begin
                        window_next = 24'hFFFFFF;
                        count_next = 9'd0;
                        target_next = 9'd0;
                        ev_valid = 1'b1;
                        ev_kind = EV_NOT_SYS;
                    end
                    else
                    begin
                        phase_next = PH_SKIPLEN;
                        target_next = 9'd6;
                    end
                end
                else
                begin
                    window_next = {window_reg[15:0], b};
                end
            end
            PH_BODY:
            begin
                if (pass_reg)
                begin
                    ev_valid = 1'b1;
                    ev_kind = EV_PAYLOAD;
                    ev_pay = b;
                end
                remain_next = remain_reg - 17'd1;
                if (remain_next == 17'd0)
                begin
                    phase_next = PH_HUNT;
                    window_next = 24'hFFFFFF;
                    count_next = 9'd0;
                    target_next = 9'd0;
                end
            end
            default:
            begin
                wr_en = 1'b1;
                count_next = count_reg + 9'd1;
                // Chained transitions of the model settle in one step: each
                // only follows when the new target already equals the count.
                if (count_next == target_reg)
                begin
                    unique case (phase_reg)
                        PH_PACK:
                        begin
                            if (h4[7:6] == 2'b01)
                            begin
                                phase_next = PH_PACK2_LEN;
                                target_next = 9'd14;
                            end
                            else
                            begin
                                if (h4[7:4] != 4'h2)
                                begin
                                    ev_valid = 1'b1;
                                    ev_kind = EV_BAD_PACK;
                                end
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_PACK2_LEN:
                        begin
                            target_next = 9'd14 + {6'd0, h13[2:0]};
                            if (h13[2:0] == 3'd0)
                                phase_next = PH_HUNT;
                            else
                                phase_next = PH_PACK2_STUFF;
                        end
                        PH_PACK2_STUFF:
                            phase_next = PH_HUNT;
                        PH_PES_START:
                        begin
                            if (h6[7:6] == 2'b10)
                            begin
                                phase_next = PH_PES2_LEN;
                                target_next = 9'd9;
                            end
                            else
                            begin
                                // MPEG-1: byte 6 is itself evaluated as stuffing.
                                if (b == 8'hFF)
                                begin
                                    phase_next = PH_PES1_STUFF;
                                    target_next = 9'd8;
                                end
                                else
                                    pts_ok = 1'b1;
                            end
                        end
                        PH_PES2_LEN:
                        begin
                            target_next = 9'd9 + {1'b0, h8};
                            if (h8 == 8'd0)
                            begin
                                if (total > 17'd9)
                                begin
                                    remain_next = total - 17'd9;
                                    pass_next = 1'b1;
                                    phase_next = PH_BODY;
                                end
                                else
                                    phase_next = PH_HUNT;
                            end
                            else
                                phase_next = PH_PES2_BODY;
                        end
                        PH_PES2_BODY:
                        begin
                            if (h7[7] && target_reg >= 9'd14)
                            begin
                                ev_valid = 1'b1;
                                ev_kind = EV_PTS;
                                ev_pts = pts_of(h9_reg, h10_reg, h11_reg, h12_reg, h13);
                            end
                            if (total > {8'd0, target_reg})
                            begin
                                remain_next = total - {8'd0, target_reg};
                                pass_next = 1'b1;
                                phase_next = PH_BODY;
                            end
                            else
                                phase_next = PH_HUNT;
                        end
                        PH_PES1_STUFF:
                        begin
                            if (target_reg > 9'(STUFFING_LIMIT))
                            begin
                                ev_valid = 1'b1;
                                ev_kind = EV_STUFF_OVF;
                                pts_ok = 1'b1;
                            end
                            else if (b == 8'hFF)
                                target_next = target_reg + 9'd1;
                            else
                                pts_ok = 1'b1;
                        end
                        PH_PES1_STD:
                        begin
                            tgt = target_reg;
                            if (nib == 4'h2)
                            begin
                                target_next = tgt + 9'd4;
                                phase_next = PH_PES1_PTS;
                            end
                            else if (nib == 4'h3)
                            begin
                                target_next = tgt + 9'd9;
                                phase_next = PH_PES1_PTSDTS;
                            end
                            else
                            begin
                                if (total > {8'd0, tgt})
                                begin
                                    remain_next = total - {8'd0, tgt};
                                    pass_next = 1'b1;
                                    phase_next = PH_BODY;
                                end
                                else
                                    phase_next = PH_HUNT;
                            end
                        end
                        PH_PES1_PTS, PH_PES1_PTSDTS:
                        begin
                            ev_valid = 1'b1;
                            ev_kind = EV_PTS;
                            // The PTS ends the header for PTS only; with a DTS
                            // it sits five bytes further back.
                            if (phase_reg == PH_PES1_PTS)
                                ev_pts = pts_of(p5_reg, p6_reg, p7_reg, p8_reg,
                                                keep_byte);
                            else
                                ev_pts = pts_of(p0_reg, p1_reg, p2_reg, p3_reg,
                                                p4_reg);
                            if (total > {8'd0, target_reg})
                            begin
                                remain_next = total - {8'd0, target_reg};
                                pass_next = 1'b1;
                                phase_next = PH_BODY;
                            end
                            else
                                phase_next = PH_HUNT;
                        end
                        PH_SKIPLEN:
                        begin
                            remain_next = {1'b0, h4, h5};
                            if ({h4, h5} == 16'd0)
                                phase_next = PH_HUNT;
                            else
                            begin
                                pass_next = 1'b0;
                                phase_next = PH_BODY;
                            end
                        end
                        default:
                            phase_next = PH_HUNT;
                    endcase
                    // MPEG-1 marker and skip evaluation of the current byte.
                    if (pts_ok)
                    begin
                        tgt = target_reg;
                        if (b[7:6] == 2'b01)
                        begin
                            target_next = tgt + 9'd2;
                            phase_next = PH_PES1_STD;
                        end
                        else if (nib == 4'h2)
                        begin
                            target_next = tgt + 9'd4;
                            phase_next = PH_PES1_PTS;
                        end
                        else if (nib == 4'h3)
                        begin
                            target_next = tgt + 9'd9;
                            phase_next = PH_PES1_PTSDTS;
                        end
                        else if (total > {8'd0, tgt})
                        begin
                            remain_next = total - {8'd0, tgt};
                            pass_next = 1'b1;
                            phase_next = PH_BODY;
                        end
                        else
                            phase_next = PH_HUNT;
                    end
                    if (phase_next == PH_HUNT)
                    begin
                        window_next = 24'hFFFFFF;
                        count_next = 9'd0;
                        target_next = 9'd0;
                    end
                end
            end
        endcase
    end

    // The PTS window of the nine header bytes before the current one, and header bytes 4 to 13.
    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            p0_reg <= p1_reg;
            p1_reg <= p2_reg;
            p2_reg <= p3_reg;
            p3_reg <= p4_reg;
            p4_reg <= p5_reg;
            p5_reg <= p6_reg;
            p6_reg <= p7_reg;
            p7_reg <= p8_reg;
            p8_reg <= keep_byte;
            if (count_reg == 9'd4) h4_reg <= data_byte;
            if (count_reg == 9'd5) h5_reg <= data_byte;
            if (count_reg == 9'd6) h6_reg <= data_byte;
            if (count_reg == 9'd7) h7_reg <= data_byte;
            if (count_reg == 9'd8) h8_reg <= data_byte;
            if (count_reg == 9'd9) h9_reg <= data_byte;
            if (count_reg == 9'd10) h10_reg <= data_byte;
            if (count_reg == 9'd11) h11_reg <= data_byte;
            if (count_reg == 9'd12) h12_reg <= data_byte;
            if (count_reg == 9'd13) h13_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= 24'hFFFFFF;
            count_reg  <= 9'd0;
            target_reg <= 9'd0;
            remain_reg <= 17'd0;
            pass_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            target_reg <= target_next;
            remain_reg <= remain_next;
            pass_reg   <= pass_next;
        end
    end

    assign res_valid = step && ev_valid;
    assign res.event_kind = ev_kind;
    assign res.payload_byte = ev_pay;
    assign res.time_stamp = ev_pts;
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program stream demux testbench
// Feeds pack headers, PES packets of both syntaxes, skipped packets, end
// codes and noise through the byte channel under random idling on both
// sides. A scoreboard predicts every event from the accepted bytes and
// compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import psd_pkg::*;

    localparam int STORE_DEPTH  = 32;
    localparam int STUFF_LIMIT  = 23;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_BYTES  = 50;
    localparam logic [7:0] RESET_SELECT = 8'hE0;

    class demux_scoreboard;
        logic [7:0]  select_id;
        phase_t      phase;
        logic [23:0] window;
        logic [7:0]  store [STORE_DEPTH];
        logic [8:0]  count;
        logic [8:0]  target;
        logic [16:0] remaining;
        bit          passing;
        logic [31:0] pts;
        result_t     pending[$];
        int          errors;

        function new();
            select_id = RESET_SELECT;
            passing = 0;
            remaining = '0;
            pts = '0;
            errors = 0;
            hunt();
        endfunction

        function void hunt();
            phase = PH_HUNT;
            window = 24'hFFFFFF;
            count = '0;
            target = '0;
        endfunction

        function logic [31:0] hb(int unsigned i);
            return (i < STORE_DEPTH) ? {24'd0, store[i[4:0]]} : 32'd0;
        endfunction

        function logic [31:0] pts_from(int unsigned base);
            return ((hb(base) >> 1) << 30) | (hb(base + 1) << 22) |
                   ((hb(base + 2) >> 1) << 15) | (hb(base + 3) << 7) |
                   (hb(base + 4) >> 1);
        endfunction

        function void close_header();
            logic [31:0] total;
            total = 32'd6 + (hb(4) << 8) + hb(5);
            if (total > {23'd0, target}) begin
                remaining = 17'(total - {23'd0, target});
                passing = 1;
                phase = PH_BODY;
            end
            else
                hunt();
        endfunction

        function void check_marker(logic [7:0] b);
            if (b[7:4] == 4'h2) begin
                target = target + 9'd4;
                phase = PH_PES1_PTS;
            end
            else if (b[7:4] == 4'h3) begin
                target = target + 9'd9;
                phase = PH_PES1_PTSDTS;
            end
            else
                close_header();
        endfunction

        function void check_std(logic [7:0] b);
            if ((b & 8'hC0) == 8'h40) begin
                target = target + 9'd2;
                phase = PH_PES1_STD;
            end
            else
                check_marker(b);
        endfunction

        function int advance(logic [7:0] cur);
            int kind;
            kind = -1;
            while (phase != PH_HUNT && phase != PH_BODY && count == target) begin
                case (phase)
                    PH_PACK:
                        if ((hb(4) & 32'hC0) == 32'h40) begin
                            target = 9'd14;
                            phase = PH_PACK2_LEN;
                        end
                        else if ((hb(4) & 32'hF0) == 32'h20)
                            hunt();
                        else begin
                            hunt();
                            kind = EV_BAD_PACK;
                        end
                    PH_PACK2_LEN:
                    begin
                        target = 9'(32'd14 + (hb(13) & 32'd7));
                        phase = PH_PACK2_STUFF;
                    end
                    PH_PACK2_STUFF: hunt();
                    PH_PES_START:
                        if ((hb(6) & 32'hC0) == 32'h80) begin
                            target = 9'd9;
                            phase = PH_PES2_LEN;
                        end
                        else
                            phase = PH_PES1_STUFF;
                    PH_PES2_LEN:
                    begin
                        target = 9'(32'd9 + hb(8));
                        phase = PH_PES2_BODY;
                    end
                    PH_PES2_BODY:
                    begin
                        if ((hb(7) & 32'h80) != 0 && target >= 9'd14) begin
                            pts = pts_from(9);
                            kind = EV_PTS;
                        end
                        close_header();
                    end
                    PH_PES1_STUFF:
                        if (target > 9'(STUFF_LIMIT)) begin
                            kind = EV_STUFF_OVF;
                            check_std(cur);
                        end
                        else if (cur == 8'hFF)
                            target = target + 9'd1;
                        else
                            check_std(cur);
                    PH_PES1_STD: check_marker(cur);
                    PH_PES1_PTS:
                    begin
                        pts = pts_from(target - 9'd5);
                        kind = EV_PTS;
                        close_header();
                    end
                    PH_PES1_PTSDTS:
                    begin
                        pts = pts_from(target - 9'd10);
                        kind = EV_PTS;
                        close_header();
                    end
                    PH_SKIPLEN:
                    begin
                        remaining = 17'((hb(4) << 8) | hb(5));
                        if (remaining == 0)
                            hunt();
                        else begin
                            passing = 0;
                            phase = PH_BODY;
                        end
                    end
                    default: hunt();
                endcase
            end
            return kind;
        endfunction

        function int route(logic [7:0] id);
            if (id == ID_END) begin
                hunt();
                return EV_PROG_END;
            end
            if (id == ID_PACK) begin
                phase = PH_PACK;
                target = 9'd12;
            end
            else if (id == select_id) begin
                phase = PH_PES_START;
                target = 9'd7;
            end
            else if (id < ID_END) begin
                hunt();
                return EV_NOT_SYS;
            end
            else begin
                phase = PH_SKIPLEN;
                target = 9'd6;
            end
            return -1;
        endfunction

        function void note_byte(logic [7:0] b);
            int kind;
            logic [7:0] pay;
            result_t r;
            kind = -1;
            pay = '0;
            if (phase == PH_HUNT) begin
                if (window == 24'h000001) begin
                    store[0] = 8'h00;
                    store[1] = 8'h00;
                    store[2] = 8'h01;
                    store[3] = b;
                    count = 9'd4;
                    kind = route(b);
                end
                else
                    window = {window[15:0], b};
            end
            else if (phase == PH_BODY) begin
                if (passing) begin
                    kind = EV_PAYLOAD;
                    pay = b;
                end
                remaining = remaining - 17'd1;
                if (remaining == 0)
                    hunt();
            end
            else begin
                if (count < STORE_DEPTH)
                    store[count[4:0]] = b;
                count = count + 9'd1;
                kind = advance(b);
            end
            if (kind >= 0) begin
                r.event_kind = kind[2:0];
                r.payload_byte = pay;
                r.time_stamp = (kind == EV_PTS) ? pts : 32'd0;
                pending.push_back(r);
            end
        endfunction

        function void check_event(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected event kind %0d byte %h pts %h", $time,
                         got.event_kind, got.payload_byte, got.time_stamp);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.event_kind !== want.event_kind) begin
                $display("%0t: event_kind expected %0d actual %0d", $time,
                         want.event_kind, got.event_kind);
                errors++;
            end
            if (got.payload_byte !== want.payload_byte) begin
                $display("%0t: payload_byte expected %h actual %h", $time,
                         want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.time_stamp !== want.time_stamp) begin
                $display("%0t: time_stamp expected %h actual %h", $time,
                         want.time_stamp, got.time_stamp);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_data;

    psd_byte_if  in_ch();
    psd_event_if out_ch();

    program_stream_demux dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    demux_scoreboard sb;
    logic [7:0] stream_bytes[$];
    bit calm;
    bit long_hold;
    bit hold_done;
    int sent;
    int idle_cycles;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Output side: random stall bursts, one long hold-off on request.
    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold) begin
                out_ch.ready <= 0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 0;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
                out_ch.ready <= 1;
        end
    end

    initial
    begin
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.event_kind = out_ch.event_kind;
                got.payload_byte = out_ch.payload_byte;
                got.time_stamp = out_ch.time_stamp;
                sb.check_event(got);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic flush_bytes();
        while (stream_bytes.size() > 0)
            send_byte(stream_bytes.pop_front());
    endtask

    task automatic write_select(logic [7:0] value);
        flush_bytes();
        in_ch.valid <= 0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        sb.select_id = value;
    endtask

    function automatic void put_start(logic [7:0] id);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h01);
        stream_bytes.push_back(id);
    endfunction

    function automatic void put_random(int n);
        repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_len(int len);
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(len[7:0]);
    endfunction

    // MPEG-1 pack is 12 bytes; anything not marked as either syntax is bad.
    function automatic void put_pack1(bit broken);
        put_start(ID_PACK);
        stream_bytes.push_back(broken ? ($urandom_range(0, 1) ? 8'h00 : 8'hC5)
                                      : (8'h20 | 8'($urandom_range(0, 15))));
        put_random(7);
    endfunction

    function automatic void put_pack2(int stuffing);
        put_start(ID_PACK);
        stream_bytes.push_back(8'h40 | 8'($urandom_range(0, 63)));
        put_random(8);
        stream_bytes.push_back((8'($urandom_range(0, 255)) & 8'hF8) |
                               {5'd0, stuffing[2:0]});
        repeat (stuffing) stream_bytes.push_back(8'hFF);
    endfunction

    function automatic void put_pes2(logic [7:0] id, bit with_pts, int hdr_len,
                                     int pay_len, int len_trim);
        int len;
        len = 3 + hdr_len + pay_len - len_trim;
        if (len < 0)
            len = 0;
        put_start(id);
        put_len(len);
        stream_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        stream_bytes.push_back(with_pts ? (8'h80 | 8'($urandom_range(0, 127)))
                                        : 8'($urandom_range(0, 127)));
        stream_bytes.push_back(hdr_len[7:0]);
        put_random(hdr_len + pay_len);
    endfunction

    // marker: 0 none, 1 PTS only, 2 PTS and DTS.
    function automatic void put_pes1(logic [7:0] id, int stuffing, bit with_std,
                                     int marker, int pay_len);
        int hdr;
        hdr = stuffing + (with_std ? 2 : 0) + ((marker == 1) ? 5 : (marker == 2) ? 10 : 1);
        put_start(id);
        put_len(hdr + pay_len);
        repeat (stuffing) stream_bytes.push_back(8'hFF);
        if (with_std) begin
            stream_bytes.push_back(8'h40 | 8'($urandom_range(0, 63)));
            stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (marker == 1) begin
            stream_bytes.push_back(8'h20 | 8'($urandom_range(0, 15)));
            put_random(4);
        end
        else if (marker == 2) begin
            stream_bytes.push_back(8'h30 | 8'($urandom_range(0, 15)));
            put_random(9);
        end
        else
            stream_bytes.push_back(8'h0F);
        put_random(pay_len);
    endfunction

    function automatic void put_skip(logic [7:0] id, int len);
        put_start(id);
        put_len(len);
        put_random(len);
    endfunction

    function automatic logic [7:0] other_id(bit system);
        logic [7:0] id;
        do
            id = system ? 8'($urandom_range(8'hBB, 8'hFF)) : 8'($urandom_range(0, 8'hB8));
        while (id == sb.select_id);
        return id;
    endfunction

    function automatic void put_random_packet();
        case ($urandom_range(0, 15))
            0: put_pack1(0);
            1: put_pack1($urandom_range(0, 3) == 0);
            2: put_pack2($urandom_range(0, 7));
            3, 4, 5: put_pes2(sb.select_id, 1'($urandom_range(0, 1)), $urandom_range(0, 12),
                              $urandom_range(0, 8), ($urandom_range(0, 5) == 0) ?
                              $urandom_range(0, 20) : 0);
            6, 7, 8: put_pes1(sb.select_id, ($urandom_range(0, 7) == 0) ?
                              $urandom_range(15, 22) : $urandom_range(0, 4),
                              1'($urandom_range(0, 1)), $urandom_range(0, 2),
                              $urandom_range(0, 8));
            9, 10: put_skip(other_id(1), $urandom_range(0, 6));
            11: put_start(ID_END);
            12: put_start(other_id(0));
            13: put_random($urandom_range(1, 6));
            default:
            begin
                // Broken start code followed by noise.
                stream_bytes.push_back(8'h00);
                stream_bytes.push_back(8'h01);
                put_random($urandom_range(1, 4));
            end
        endcase
    endfunction

    initial
    begin
        logic [7:0] selects[6];
        int p;
        sb = new();
        calm = 0;
        long_hold = 0;
        hold_done = 0;
        sent = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.data_byte = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part with the reset selection.
        put_pack1(0);
        put_pack1(1);
        put_pack2(7);
        put_pes2(RESET_SELECT, 1, 5, 2, 0);
        put_pes2(RESET_SELECT, 1, 3, 1, 0);
        put_pes2(RESET_SELECT, 0, 0, 0, 3);
        put_pes1(RESET_SELECT, 2, 1, 1, 1);
        put_pes1(RESET_SELECT, 0, 0, 2, 0);
        put_pes1(RESET_SELECT, 20, 0, 0, 1);
        put_skip(8'hBE, 0);
        put_skip(8'hFF, 2);
        put_start(8'h00);
        put_start(ID_END);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h80);
        flush_bytes();

        selects[0] = 8'h00;
        selects[1] = 8'hFF;
        selects[2] = 8'hC0;
        selects[3] = 8'($urandom_range(0, 255));
        selects[4] = 8'hBD;
        selects[5] = RESET_SELECT;
        for (p = 0; p < 6; p++) begin
            write_select(selects[p]);
            if (p == 5)
                calm = 1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                put_random_packet();
                flush_bytes();
                if (p == 2 && !hold_done && sent >= 20) begin
                    long_hold = 1;
                    hold_done = 1;
                end
            end
        end

        flush_bytes();
        in_ch.valid <= 0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/psd_pkg.sv
hdl/psd_byte_if.sv
hdl/psd_event_if.sv
hdl/psd_parser.sv
hdl/program_stream_demux.sv
bench/tb.sv
